// ===== src/clarb_pkg.sv =====
`default_nettype none
package clarb_pkg;

  localparam int SESSION_BITS_DEF = 16;
  localparam int SID_WIDTH = 16;

  typedef enum logic [1:0] {
    LS_FREE     = 2'd0,
    LS_ATTACHED = 2'd1,
    LS_REMOTE   = 2'd2,
    LS_REVOKING = 2'd3
  } lease_state_t;

  typedef enum logic [2:0] {
    ACT_ATTACH   = 3'd0,
    ACT_ACTIVATE = 3'd1,
    ACT_DETACH   = 3'd2,
    ACT_TAKE_LOC = 3'd3,
    ACT_QUERY    = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_BUSY   = 2'd1,
    ERR_DENIED = 2'd2
  } err_t;

  localparam logic ORIGIN_WEB    = 1'b0;
  localparam logic ORIGIN_REMOTE = 1'b1;

  typedef struct packed {
    logic [2:0]           action;
    logic [SID_WIDTH-1:0] session_id;
    logic                 origin;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  error_code;
    logic        mode;
    logic [31:0] revision;
    logic        revoke_request;
    logic        authorized;
  } out_word_t;

endpackage
`default_nettype wire

// ===== src/clarb_core.sv =====
`default_nettype none
module clarb_core
  import clarb_pkg::*;
#(
  parameter int OWN_BITS = SID_WIDTH
) (
  input  wire lease_state_t  lease_state,
  input  wire [OWN_BITS-1:0] owner_id,
  input  wire [31:0]         revision_count,
  input  wire in_word_t      word,
  output lease_state_t       lease_state_next,
  output logic [OWN_BITS-1:0] owner_id_next,
  output logic [31:0]        revision_count_next,
  output out_word_t          result
);

  logic [OWN_BITS-1:0] sid;
  logic                is_owner;
  logic                rev_inc;

  assign sid      = word.session_id[OWN_BITS-1:0];
  assign is_owner = (owner_id == sid);

  // next state
  always_comb begin
    lease_state_next = lease_state;
    owner_id_next    = owner_id;
    rev_inc          = 1'b0;
    case (word.action)
      ACT_ATTACH: begin
        if (lease_state == LS_FREE) begin
          lease_state_next = LS_ATTACHED;
          owner_id_next    = sid;
        end
      end
      ACT_ACTIVATE: begin
        if (lease_state == LS_ATTACHED && is_owner) begin
          lease_state_next = LS_REMOTE;
          rev_inc          = 1'b1;
        end
      end
      ACT_DETACH: begin
        if (lease_state != LS_FREE && is_owner) begin
          lease_state_next = LS_FREE;
          owner_id_next    = '0;
          rev_inc          = (lease_state == LS_REMOTE);
        end
      end
      ACT_TAKE_LOC: begin
        if (lease_state == LS_ATTACHED || lease_state == LS_REMOTE) begin
          lease_state_next = LS_REVOKING;
          rev_inc          = (lease_state == LS_REMOTE);
        end
      end
      default: begin
      end
    endcase
  end

  assign revision_count_next = revision_count + {31'd0, rev_inc};

  // result
  always_comb begin
    result                = '0;
    result.mode           = (lease_state_next == LS_REMOTE);
    result.revision       = revision_count_next;
    case (word.action)
      ACT_ATTACH: begin
        if (lease_state != LS_FREE) begin
          result.error_code = ERR_BUSY;
        end
      end
      ACT_ACTIVATE: begin
        if (!((lease_state == LS_ATTACHED || lease_state == LS_REMOTE) && is_owner)) begin
          result.error_code = ERR_DENIED;
        end
      end
      ACT_DETACH: begin
        if (lease_state != LS_FREE && !is_owner) begin
          result.error_code = ERR_DENIED;
        end
      end
      ACT_TAKE_LOC: begin
        result.revoke_request = (lease_state == LS_ATTACHED || lease_state == LS_REMOTE);
      end
      ACT_QUERY: begin
        if (lease_state == LS_REMOTE) begin
          result.authorized = (word.origin == ORIGIN_REMOTE) && is_owner;
        end else begin
          result.authorized = (word.origin == ORIGIN_WEB);
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== src/control_lease_arbiter_unit.sv =====
`default_nettype none
// Channel  Handshake               Word
// in       in_valid / in_ready     in_word  (action, session_id, origin)
// out      out_valid / out_ready   out_word (error_code, mode, revision,
//                                            revoke_request, authorized)
//
// One word in per cycle while in_ready is high; its result is registered in the output register.
// The lease state, owner and revision update at the same edge the word is taken.
// in_ready is high while the output register is empty or being drained.
// Reset frees the lease, clears owner and revision, and empties the output.
module control_lease_arbiter_unit
  import clarb_pkg::*;
#(
  parameter int SESSION_BITS = SESSION_BITS_DEF
) (
  input  wire            clk,
  input  wire            rst,
  input  wire            in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire            out_ready,
  output out_word_t      out_word
);

  localparam int OWN_BITS = (SESSION_BITS < SID_WIDTH) ? SESSION_BITS : SID_WIDTH;

  lease_state_t        lease_state;
  lease_state_t        lease_state_next;
  logic [OWN_BITS-1:0] owner_id;
  logic [OWN_BITS-1:0] owner_id_next;
  logic [31:0]         revision_count;
  logic [31:0]         revision_count_next;
  out_word_t           result;
  logic                take;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  clarb_core #(
    .OWN_BITS(OWN_BITS)
  ) u_core (
    .lease_state         (lease_state),
    .owner_id            (owner_id),
    .revision_count      (revision_count),
    .word                (in_word),
    .lease_state_next    (lease_state_next),
    .owner_id_next       (owner_id_next),
    .revision_count_next (revision_count_next),
    .result              (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      lease_state    <= LS_FREE;
      owner_id       <= '0;
      revision_count <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (take) begin
        lease_state    <= lease_state_next;
        owner_id       <= owner_id_next;
        revision_count <= revision_count_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_word <= result;
    end
  end

endmodule
`default_nettype wire
